// ----- rtl/dnsqx_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnsqx_pkg
// Shared constants for the DNS question-name extractor: header size, name
// length limit, name separator and the status codes returned on the last item.
// ----------------------------------------------------------------------------
package dnsqx_pkg;

	localparam logic [3:0] HEADER_BYTES   = 4'd12;
	localparam logic [7:0] MAX_NAME_CHARS = 8'd254;
	localparam logic [7:0] DOT_CHAR       = 8'h2E;
	localparam logic [7:0] HYPHEN_CHAR    = 8'h2D;

	typedef logic [2:0] status_t;

	localparam status_t ST_OK      = 3'd0;
	localparam status_t ST_SHORT   = 3'd1;
	localparam status_t ST_BADLEN  = 3'd2;
	localparam status_t ST_BADCHAR = 3'd3;
	localparam status_t ST_LONG    = 3'd4;
	localparam status_t ST_EMPTY   = 3'd5;

endpackage

// ----- rtl/dns_qname_extractor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dns_qname_extractor
// Streaming parser that pulls the question name out of a DNS message.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one message byte per item in s_tdata, s_tlast on the
//   final byte of the message. The 12-byte header is skipped, then the
//   length-prefixed labels of the question name are walked.
//   Output channel m_*: one item per emitted name character (label byte or
//   dot between labels) and one on the final message byte; m_tlast marks the
//   final item, which carries the status and the name length. Both can share
//   one item. On a nonzero status the receiver drops the characters it got.
//   Each item is valid in the cycle after its byte is accepted. One byte is taken
//   every cycle; the single output register is reloaded in the same cycle it
//   is drained, so s_tready stays high unless that register holds an item and
//   m_tready is low. Bytes that produce nothing are still accepted.
//   Reset clears the parse state to the header phase and empties the output
//   register. After the final byte the parser returns to the header phase.
// ----------------------------------------------------------------------------
module dns_qname_extractor
	import dnsqx_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // msg_byte
	input  logic        s_tlast,   // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // name_char[7:0], status[10:8], name_length[18:11], zero pad
	output logic        m_tuser,   // char_valid
	output logic        m_tlast    // done_res
);

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_LENGTH,
		PH_LABEL,
		PH_LABEL_BAD,
		PH_STOP
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [3:0]  header_count_q, header_count_n;
	logic [6:0]  label_left_q, label_left_n;
	logic [7:0]  name_count_q, name_count_n;
	status_t     error_code_q, error_code_n;
	logic        label_seen_q, label_seen_n;

	logic        emit;
	logic [7:0]  ch;
	status_t     st;
	logic        accept;

	logic        out_valid_q;
	logic        out_char_valid_q;
	logic [7:0]  out_char_q;
	logic        out_done_q;
	status_t     out_status_q;
	logic [7:0]  out_len_q;

	function automatic logic char_ok(input logic [7:0] c);
		char_ok = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
			(c >= 8'h61 && c <= 8'h7A) || (c == HYPHEN_CHAR);
	endfunction

	assign accept   = s_tvalid && s_tready;
	assign s_tready = !out_valid_q || m_tready;

	always_comb begin
		phase_n        = phase_q;
		header_count_n = header_count_q;
		label_left_n   = label_left_q;
		name_count_n   = name_count_q;
		error_code_n   = error_code_q;
		label_seen_n   = label_seen_q;
		emit           = 1'b0;
		ch             = 8'd0;
		case (phase_q)
			PH_HEADER: begin
				header_count_n = header_count_q + 4'd1;
				if (header_count_n >= HEADER_BYTES) begin
					phase_n = PH_LENGTH;
				end
			end
			PH_LENGTH: begin
				if (s_tdata == 8'd0) begin
					phase_n = PH_STOP;
				end else if (s_tdata[7]) begin
					error_code_n = ST_BADLEN;
					phase_n      = PH_STOP;
				end else begin
					label_left_n = s_tdata[6:0];
					phase_n      = PH_LABEL;
					if (label_seen_q) begin
						if (name_count_q < MAX_NAME_CHARS) begin
							emit         = 1'b1;
							ch           = DOT_CHAR;
							name_count_n = name_count_q + 8'd1;
						end else begin
							error_code_n = ST_LONG;
							phase_n      = PH_LABEL_BAD;
						end
					end
					label_seen_n = 1'b1;
				end
			end
			PH_LABEL, PH_LABEL_BAD: begin
				if (phase_q == PH_LABEL) begin
					if (!char_ok(s_tdata)) begin
						error_code_n = ST_BADCHAR;
						phase_n      = PH_LABEL_BAD;
					end else if (name_count_q >= MAX_NAME_CHARS) begin
						error_code_n = ST_LONG;
						phase_n      = PH_LABEL_BAD;
					end else begin
						emit         = 1'b1;
						ch           = s_tdata;
						name_count_n = name_count_q + 8'd1;
					end
				end
				label_left_n = label_left_q - 7'd1;
				if (label_left_n == 7'd0) begin
					phase_n = (phase_n == PH_LABEL_BAD) ? PH_STOP : PH_LENGTH;
				end
			end
			default: begin
			end
		endcase

		if (phase_n == PH_HEADER) begin
			st = ST_SHORT;
		end else if ((phase_n == PH_LABEL || phase_n == PH_LABEL_BAD) &&
				label_left_n != 7'd0) begin
			st = ST_BADLEN;
		end else if (error_code_n != ST_OK) begin
			st = error_code_n;
		end else if (name_count_n == 8'd0) begin
			st = ST_EMPTY;
		end else begin
			st = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_HEADER;
			header_count_q <= 4'd0;
			label_left_q   <= 7'd0;
			name_count_q   <= 8'd0;
			error_code_q   <= ST_OK;
			label_seen_q   <= 1'b0;
			out_valid_q    <= 1'b0;
		end else if (accept) begin
			out_valid_q <= emit || s_tlast;
			if (s_tlast) begin
				phase_q        <= PH_HEADER;
				header_count_q <= 4'd0;
				label_left_q   <= 7'd0;
				name_count_q   <= 8'd0;
				error_code_q   <= ST_OK;
				label_seen_q   <= 1'b0;
			end else begin
				phase_q        <= phase_n;
				header_count_q <= header_count_n;
				label_left_q   <= label_left_n;
				name_count_q   <= name_count_n;
				error_code_q   <= error_code_n;
				label_seen_q   <= label_seen_n;
			end
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload of the output register
	always_ff @(posedge clk) begin
		if (accept) begin
			out_char_valid_q <= emit;
			out_char_q       <= ch;
			out_done_q       <= s_tlast;
			out_status_q     <= s_tlast ? st : ST_OK;
			out_len_q        <= s_tlast ? name_count_n : 8'd0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_char_valid_q;
	assign m_tlast  = out_done_q;
	assign m_tdata  = {5'd0, out_len_q, out_status_q, out_char_q};

	a_nonlast_has_char: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tuser)
		else $error("non-final item without a character");

	a_char_zero_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[7:0] == 8'd0)
		else $error("character field set without char flag");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[10:8] <= ST_EMPTY)
		else $error("status out of range");

	a_empty_has_no_length: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast && m_tdata[10:8] == ST_EMPTY |-> m_tdata[18:11] == 8'd0)
		else $error("empty status with nonzero name length");

	a_label_left_in_label: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_LABEL || phase_q == PH_LABEL_BAD |-> label_left_q != 7'd0)
		else $error("label phase with no bytes left");

endmodule
